>>> hdl/afu_pkg.sv
`timescale 1ns / 1ps
package afu_pkg;

   localparam int SampleWidth = 16;
   localparam int FracBits = 32;
   localparam int DivSteps = 32;
   localparam int LogSteps = 33;
   localparam int TableAddrBitsDefault = 8;

   localparam int CsrAddrWidth = 4;
   localparam logic [CsrAddrWidth-1:0] ADDR_FUNCTION_KIND = 4'h0;
   localparam logic [CsrAddrWidth-1:0] ADDR_DERIVATIVE_MODE = 4'h4;
   localparam logic [CsrAddrWidth-1:0] ADDR_ELU_ALPHA = 4'h8;

   localparam logic [13:0] ELU_ALPHA_RESET = 14'd2048;
   localparam logic signed [17:0] ONE_Q11 = 18'sd2048;
   localparam logic signed [17:0] HSIG_LIMIT = 18'sd6144;
   localparam logic signed [17:0] HSIG_BIAS = 18'sd6147;
   localparam logic signed [17:0] HSIG_SLOPE = 18'sd341;
   localparam logic [13:0] RECIP_SIX = 14'd10923;

   typedef enum logic [2:0] {
      KIND_IDENTITY = 3'd0,
      KIND_RELU     = 3'd1,
      KIND_ELU      = 3'd2,
      KIND_SIGMOID  = 3'd3,
      KIND_LOGSIG   = 3'd4,
      KIND_HARDSIG  = 3'd5,
      KIND_TANH     = 3'd6
   } kind_type;

   // sideband that rides along the divide and log chains
   typedef struct packed {
      logic signed [SampleWidth-1:0] x;
      logic [FracBits:0]             u;
   } side_type;

   // e^-a in unsigned Q32, evaluated at elaboration only
   function automatic logic [FracBits:0] exp_q32(input real a);
      real r;
      begin
         r = $exp(-a) * (2.0 ** FracBits);
         return (FracBits + 1)'(longint'(r));
      end
   endfunction

   // ln(1 + 2^-k) in unsigned Q32, evaluated at elaboration only
   function automatic logic [FracBits-1:0] ln_q32(input int k);
      real r;
      begin
         r = $ln(1.0 + 2.0 ** (-k)) * (2.0 ** FracBits);
         return FracBits'(longint'(r));
      end
   endfunction

endpackage

>>> hdl/afu_div_log.sv
`timescale 1ns / 1ps
module afu_div_log import afu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [FracBits:0]     in_w,
   input  side_type              in_side,
   output logic                  out_valid,
   output logic [FracBits-1:0]   out_t,
   output logic [FracBits-1:0]   out_ln,
   output side_type              out_side
);

   typedef struct packed {
      logic                  valid;
      logic [FracBits+1:0]   rem;
      logic [FracBits+1:0]   den;
      logic [FracBits-1:0]   quo;
      side_type              side;
   } div_stage_type;

   typedef struct packed {
      logic                  valid;
      logic [FracBits+1:0]   z;
      logic [FracBits-1:0]   acc;
      logic [FracBits-1:0]   t;
      side_type              side;
   } log_stage_type;

   localparam logic [FracBits+1:0] OneQ32 = (FracBits + 2)'(1) << FracBits;
   localparam logic [FracBits+2:0] OneQ33 = (FracBits + 3)'(1) << (FracBits + 1);

   div_stage_type div_ff [DivSteps];
   log_stage_type log_ff [LogSteps];

   // t = (1 - w) / (1 + w), one quotient bit per stage
   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      div_stage_type prev;
      div_stage_type div_in;
      logic [FracBits+2:0] shifted;
      if (g == 0) begin : g_head
         always_comb begin
            prev.valid = in_valid;
            prev.rem   = OneQ32 - (FracBits + 2)'(in_w);
            prev.den   = OneQ32 + (FracBits + 2)'(in_w);
            prev.quo   = '0;
            prev.side  = in_side;
         end
      end else begin : g_body
         assign prev = div_ff[g-1];
      end
      always_comb begin
         shifted = {prev.rem, 1'b0};
         div_in = prev;
         if (shifted >= {1'b0, prev.den}) begin
            div_in.rem = (FracBits + 2)'(shifted - {1'b0, prev.den});
            div_in.quo = {prev.quo[FracBits-2:0], 1'b1};
         end else begin
            div_in.rem = shifted[FracBits+1:0];
            div_in.quo = {prev.quo[FracBits-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[g].valid <= 1'b0;
         end else if (advance) begin
            div_ff[g] <= div_in;
         end
      end
   end

   // ln(1/sp) by multiplicative normalization of sp toward one
   for (genvar g = 0; g < LogSteps; g++) begin : g_log
      localparam logic [FracBits-1:0] LnStep = ln_q32(g + 1);
      log_stage_type prev;
      log_stage_type log_in;
      logic [FracBits+2:0] trial;
      if (g == 0) begin : g_head
         always_comb begin
            prev.valid = div_ff[DivSteps-1].valid;
            prev.t     = div_ff[DivSteps-1].quo;
            prev.z     = OneQ32 + (FracBits + 2)'(div_ff[DivSteps-1].quo);
            prev.acc   = '0;
            prev.side  = div_ff[DivSteps-1].side;
         end
      end else begin : g_body
         assign prev = log_ff[g-1];
      end
      always_comb begin
         trial = (FracBits + 3)'(prev.z) + (FracBits + 3)'(prev.z >> (g + 1));
         log_in = prev;
         if (trial <= OneQ33) begin
            log_in.z   = trial[FracBits+1:0];
            log_in.acc = prev.acc + LnStep;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            log_ff[g].valid <= 1'b0;
         end else if (advance) begin
            log_ff[g] <= log_in;
         end
      end
   end

   assign out_valid = log_ff[LogSteps-1].valid;
   assign out_t     = log_ff[LogSteps-1].t;
   assign out_ln    = log_ff[LogSteps-1].acc;
   assign out_side  = log_ff[LogSteps-1].side;

endmodule

>>> hdl/activation_function_unit.sv
`timescale 1ns / 1ps
// Elementwise activation unit: one signed Q4.11 sample in, one Q4.11 result out.
// Request channel: req_valid / req_stall carry req_sample_in; a beat moves on a
// rising edge with valid high and stall low.
// Response channel: rsp_valid / rsp_stall carry rsp_result_out and rsp_saturated.
// The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
// function_kind at 0x0, derivative_mode at 0x4 and elu_alpha at 0x8.
// A request beat passes through capture, table lookup, e^-|x| and u^2 multiply
// stages, 32 restoring divide stages (one quotient bit each), 33 log normalization
// stages and 2 output stages. Throughput is one beat per cycle while the response
// is not stalled; the divide and log chains are fully pipelined.
// A stalled response holds the whole pipeline in place and raises req_stall the
// same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and returns the registers to identity, forward
// mode and alpha of 1.0. Change registers only while the pipeline is empty.
module activation_function_unit import afu_pkg::*; #(
   parameter int TABLE_ADDR_BITS = TableAddrBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SampleWidth-1:0]  req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SampleWidth-1:0]  rsp_result_out,
   output logic                           rsp_saturated,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [CsrAddrWidth-1:0]        paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int LoDepth = 2 ** TABLE_ADDR_BITS;
   localparam int HiBits = SampleWidth - TABLE_ADDR_BITS;
   localparam int HiDepth = 2 ** HiBits;

   // ---------------- configuration registers ----------------
   kind_type    kind_ff;
   logic        deriv_ff;
   logic [13:0] alpha_ff;
   logic        csr_write;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_IDENTITY;
         deriv_ff <= 1'b0;
         alpha_ff <= ELU_ALPHA_RESET;
      end else if (csr_write) begin
         if (paddr == ADDR_FUNCTION_KIND) kind_ff <= kind_type'(pwdata[2:0]);
         if (paddr == ADDR_DERIVATIVE_MODE) deriv_ff <= pwdata[0];
         if (paddr == ADDR_ELU_ALPHA) alpha_ff <= pwdata[13:0];
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr)
         ADDR_FUNCTION_KIND:   prdata = {29'd0, kind_ff};
         ADDR_DERIVATIVE_MODE: prdata = {31'd0, deriv_ff};
         ADDR_ELU_ALPHA:       prdata = {18'd0, alpha_ff};
         default:              prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // The whole pipeline moves together; a held response freezes every stage.
   logic advance;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------- exp tables ----------------
   // e^-|x| = e^-(high part) * e^-(low part), both tables built at elaboration
   logic [FracBits:0] exp_lo_rom [LoDepth];
   logic [FracBits:0] exp_hi_rom [HiDepth];
   for (genvar g = 0; g < LoDepth; g++) begin : g_lo
      assign exp_lo_rom[g] = exp_q32(real'(g) / 2048.0);
   end
   for (genvar g = 0; g < HiDepth; g++) begin : g_hi
      assign exp_hi_rom[g] = exp_q32(real'(g) * real'(LoDepth) / 2048.0);
   end

   // stage 1: capture the sample
   logic                          s1_valid_ff;
   logic signed [SampleWidth-1:0] s1_x_ff;
   logic [SampleWidth-1:0]        s1_ax;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s1_x_ff     <= req_sample_in;
      end
   end

   assign s1_ax = s1_x_ff[SampleWidth-1] ? SampleWidth'(-s1_x_ff) : s1_x_ff;

   // stage 2: table lookup
   logic                          s2_valid_ff;
   logic signed [SampleWidth-1:0] s2_x_ff;
   logic [FracBits:0]             s2_lo_ff;
   logic [FracBits:0]             s2_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
         s2_x_ff     <= s1_x_ff;
         s2_lo_ff    <= exp_lo_rom[s1_ax[TABLE_ADDR_BITS-1:0]];
         s2_hi_ff    <= exp_hi_rom[s1_ax[SampleWidth-1:TABLE_ADDR_BITS]];
      end
   end

   // stage 3: u = e^-|x|
   logic                          s3_valid_ff;
   logic signed [SampleWidth-1:0] s3_x_ff;
   logic [FracBits:0]             s3_u_ff;
   logic [2*FracBits+1:0]         s3_prod;

   assign s3_prod = s2_lo_ff * s2_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
         s3_x_ff     <= s2_x_ff;
         s3_u_ff     <= s3_prod[2*FracBits:FracBits];
      end
   end

   // stage 4: u^2 = e^-2|x| for tanh
   logic                          s4_valid_ff;
   side_type                      s4_side_ff;
   logic [FracBits:0]             s4_u2_ff;
   logic [2*FracBits+1:0]         s4_prod;
   logic [FracBits:0]             div_w;

   assign s4_prod = s3_u_ff * s3_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff  <= s3_valid_ff;
         s4_side_ff.x <= s3_x_ff;
         s4_side_ff.u <= s3_u_ff;
         s4_u2_ff     <= s4_prod[2*FracBits:FracBits];
      end
   end

   assign div_w = (kind_ff == KIND_TANH) ? s4_u2_ff : s4_side_ff.u;

   // divide and log chains: t = (1-w)/(1+w), ln = ln(1+w)
   logic                 dl_valid;
   logic [FracBits-1:0]  dl_t;
   logic [FracBits-1:0]  dl_ln;
   side_type             dl_side;

   afu_div_log u_div_log (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_valid_ff),
      .in_w      (div_w),
      .in_side   (s4_side_ff),
      .out_valid (dl_valid),
      .out_t     (dl_t),
      .out_ln    (dl_ln),
      .out_side  (dl_side)
   );

   // stage A: products for the derivatives, ELU and hard sigmoid
   logic                          sa_valid_ff;
   logic signed [SampleWidth-1:0] sa_x_ff;
   logic [FracBits-1:0]           sa_t_ff;
   logic [FracBits-1:0]           sa_ln_ff;
   logic [FracBits-1:0]           sa_tt_ff;
   logic [FracBits+14:0]          sa_elu_d_ff;
   logic [FracBits+14:0]          sa_elu_f_ff;
   logic [13:0]                   sa_hs_ff;
   logic [2*FracBits-1:0]         sa_tt_prod;
   logic [13:0]                   sa_hs_num;
   logic [27:0]                   sa_hs_prod;
   logic signed [17:0]            sa_hs_sum;

   assign sa_tt_prod = dl_t * dl_t;
   assign sa_hs_sum  = 18'(dl_side.x) + HSIG_BIAS;
   assign sa_hs_num  = sa_hs_sum[13:0];
   assign sa_hs_prod = sa_hs_num * RECIP_SIX;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (advance) begin
         sa_valid_ff <= dl_valid;
         sa_x_ff     <= dl_side.x;
         sa_t_ff     <= dl_t;
         sa_ln_ff    <= dl_ln;
         sa_tt_ff    <= sa_tt_prod[2*FracBits-1:FracBits];
         sa_elu_d_ff <= alpha_ff * dl_side.u;
         sa_elu_f_ff <= alpha_ff * ((FracBits + 1)'(1) << FracBits) - alpha_ff * dl_side.u;
         sa_hs_ff    <= 14'(sa_hs_prod >> 16);
      end
   end

   // stage B: round, select, clamp
   logic                  neg;
   logic signed [17:0]    ax_s;
   logic [FracBits+1:0]   one_q32;
   logic [FracBits+1:0]   s_q33;
   logic [FracBits+1:0]   oms_q33;
   logic [FracBits+1:0]   om_tt;
   logic signed [17:0]    r_sig;
   logic signed [17:0]    r_oms;
   logic signed [17:0]    r_tanh;
   logic signed [17:0]    r_tanh_d;
   logic signed [17:0]    r_sig_d;
   logic signed [17:0]    r_ln;
   logic signed [17:0]    r_elu_d;
   logic signed [17:0]    r_elu_f;
   logic signed [17:0]    x_s;
   logic signed [17:0]    v;
   logic signed [SampleWidth-1:0] result_in;
   logic                  sat_in;

   assign one_q32 = (FracBits + 2)'(1) << FracBits;

   always_comb begin
      neg     = sa_x_ff[SampleWidth-1];
      x_s     = 18'(sa_x_ff);
      ax_s    = neg ? -x_s : x_s;
      s_q33   = neg ? one_q32 - 34'(sa_t_ff) : one_q32 + 34'(sa_t_ff);
      oms_q33 = neg ? one_q32 + 34'(sa_t_ff) : one_q32 - 34'(sa_t_ff);
      om_tt   = one_q32 - 34'(sa_tt_ff);
      r_sig   = 18'((s_q33 + (34'(1) << 21)) >> 22);
      r_oms   = 18'((oms_q33 + (34'(1) << 21)) >> 22);
      r_tanh  = 18'((34'(sa_t_ff) + (34'(1) << 20)) >> 21);
      r_tanh_d = 18'((om_tt + (34'(1) << 20)) >> 21);
      r_sig_d = 18'((om_tt + (34'(1) << 22)) >> 23);
      r_ln    = 18'((34'(sa_ln_ff) + (34'(1) << 20)) >> 21);
      r_elu_d = 18'((sa_elu_d_ff + (47'(1) << 31)) >> 32);
      r_elu_f = 18'((sa_elu_f_ff + (47'(1) << 31)) >> 32);

      unique case (kind_ff)
         KIND_RELU: begin
            if (deriv_ff) v = (x_s > 0) ? ONE_Q11 : '0;
            else          v = (x_s > 0) ? x_s : '0;
         end
         KIND_ELU: begin
            if (x_s > 0) v = deriv_ff ? ONE_Q11 : x_s;
            else         v = deriv_ff ? r_elu_d : -r_elu_f;
         end
         KIND_SIGMOID: v = deriv_ff ? r_sig_d : r_sig;
         KIND_LOGSIG: begin
            if (deriv_ff) v = r_oms;
            else          v = -((neg ? ax_s : 18'sd0) + r_ln);
         end
         KIND_HARDSIG: begin
            if (x_s < -HSIG_LIMIT || x_s > HSIG_LIMIT)
               v = deriv_ff ? '0 : ((x_s > 0) ? ONE_Q11 : '0);
            else
               v = deriv_ff ? HSIG_SLOPE : 18'(sa_hs_ff);
         end
         KIND_TANH: begin
            if (deriv_ff) v = r_tanh_d;
            else          v = neg ? -r_tanh : r_tanh;
         end
         default: v = deriv_ff ? ONE_Q11 : x_s;
      endcase

      // clip to 16 bits and flag it
      priority if (v > 18'sd32767) begin
         result_in = 16'sh7FFF;
         sat_in    = 1'b1;
      end else if (v < -18'sd32768) begin
         result_in = -16'sh8000;
         sat_in    = 1'b1;
      end else begin
         result_in = v[SampleWidth-1:0];
         sat_in    = 1'b0;
      end
   end

   logic                          rsp_valid_ff;
   logic signed [SampleWidth-1:0] rsp_result_ff;
   logic                          rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= sa_valid_ff;
         rsp_result_ff <= result_in;
         rsp_sat_ff    <= sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_out = rsp_result_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

>>> tb/sv/tb_activation_function_unit.sv
`timescale 1ns / 1ps
module tb_activation_function_unit;
   import afu_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles = 100;
   localparam int MaxReports = 10;
   localparam logic [63:0] QOne = 64'h1 << 60;

   typedef struct {
      logic signed [15:0] value;
      logic               sat;
   } prediction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_result_out;
   logic rsp_saturated;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // register mirror used by the activation predictor
   kind_type    act_kind = KIND_IDENTITY;
   logic        act_deriv = 1'b0;
   logic [13:0] act_alpha = ELU_ALPHA_RESET;

   logic signed [15:0] sample_queue[$];
   prediction_type     activation_queue[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;

   activation_function_unit dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Q60 fixed-point arithmetic, truncating every product and quotient
   // ---------------------------------------------------------------
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'h0, a} * {64'h0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] q60_div(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] q;
      if (b == 0) return 64'h0;
      q = {4'h0, a, 60'h0} / {64'h0, b};
      return q[63:0];
   endfunction

   // e^-f for f in [0,1] by alternating series
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0] sum;
      logic [63:0] term;
      sum = QOne;
      term = QOne;
      for (int n = 1; n <= 26; n++) begin
         term = q60_mul(term, f) / n;
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   // e^-(k/2048): fractional part by series, integer part by repeated e^-1
   function automatic logic [63:0] exp_neg_q11(input int unsigned k);
      logic [63:0] e1;
      logic [63:0] r;
      e1 = exp_neg_frac(QOne);
      r = exp_neg_frac(64'(k & 2047) << 49);
      for (int i = 0; i < (k >> 11); i++) r = q60_mul(r, e1);
      return r;
   endfunction

   // ln(1+u) through 2*atanh(u/(2+u))
   function automatic logic [63:0] log_one_plus(input logic [63:0] u);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] sum;
      z = q60_div(u, 2 * QOne + u);
      z2 = q60_mul(z, z);
      term = z;
      sum = 0;
      for (int k = 0; k < 30; k++) begin
         sum = sum + term / (2 * k + 1);
         term = q60_mul(term, z2);
      end
      return 2 * sum;
   endfunction

   // round a Q60 magnitude to nearest Q4.11 step
   function automatic longint round_q11(input logic [63:0] mag, input logic neg);
      longint r;
      r = longint'((mag + (64'h1 << 48)) >> 49);
      return neg ? -r : r;
   endfunction

   function automatic prediction_type predict_activation(input logic signed [15:0] sample);
      longint x;
      longint v;
      logic neg;
      int unsigned ax;
      logic [63:0] u;
      logic [63:0] sp;
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] a60;
      prediction_type res;
      x = sample;
      neg = x < 0;
      ax = neg ? -x : x;
      a60 = 64'(act_alpha) << 49;
      case (act_kind)
         KIND_RELU: begin
            v = act_deriv ? (x > 0 ? 2048 : 0) : (x > 0 ? x : 0);
         end
         KIND_ELU: begin
            if (x > 0) begin
               v = act_deriv ? 2048 : x;
            end else begin
               u = exp_neg_q11(ax);
               v = act_deriv ? round_q11(q60_mul(a60, u), 1'b0)
                             : round_q11(q60_mul(a60, QOne - u), 1'b1);
            end
         end
         KIND_SIGMOID, KIND_LOGSIG: begin
            u = exp_neg_q11(ax);
            sp = q60_div(QOne, QOne + u);
            s = neg ? QOne - sp : sp;
            if (act_kind == KIND_SIGMOID)
               v = act_deriv ? round_q11(q60_mul(sp, QOne - sp), 1'b0) : round_q11(s, 1'b0);
            else if (act_deriv)
               v = round_q11(QOne - s, 1'b0);
            else
               v = -((neg ? longint'(ax) : 0) + round_q11(log_one_plus(u), 1'b0));
         end
         KIND_HARDSIG: begin
            if (x < -6144 || x > 6144) v = act_deriv ? 0 : (x > 0 ? 2048 : 0);
            else v = act_deriv ? 341 : (x + 6147) / 6;
         end
         KIND_TANH: begin
            u = exp_neg_q11(2 * ax);
            t = q60_div(QOne - u, QOne + u);
            v = act_deriv ? round_q11(QOne - q60_mul(t, t), 1'b0) : round_q11(t, neg);
         end
         default: begin
            v = act_deriv ? 2048 : x;
         end
      endcase
      res.sat = 1'b0;
      if (v > 32767) begin
         v = 32767;
         res.sat = 1'b1;
      end else if (v < -32768) begin
         v = -32768;
         res.sat = 1'b1;
      end
      res.value = 16'(v);
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps.
   // Predict each beat as it is accepted.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            activation_queue.push_back(predict_activation(req_sample_in));
            next_valid = 1'b0;
         end
         // hold a stalled beat; otherwise pick what comes next
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (sample_queue.size() != 0) begin
               req_sample_in <= sample_queue.pop_front();
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // ---------------------------------------------------------------
   // Response monitor and back-pressure. The stall pattern rotates
   // through free flow, light random, periodic blocks and heavy random.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      prediction_type exp_act;
      int mode;
      cycle_count <= cycle_count + 1;
      mode = (cycle_count / 300) % 4;
      case (mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= ((cycle_count % 37) < 10);
         default: rsp_stall <= ($urandom_range(0, 2) != 0);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         if (activation_queue.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < MaxReports)
               $display("unexpected beat: result %0d sat %0b", rsp_result_out, rsp_saturated);
         end else begin
            exp_act = activation_queue.pop_front();
            if (rsp_result_out !== exp_act.value || rsp_saturated !== exp_act.sat) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MaxReports)
                  $display("mismatch: kind %0d deriv %0b alpha %0d: exp %0d/%0b got %0d/%0b",
                           act_kind, act_deriv, act_alpha, exp_act.value, exp_act.sat,
                           rsp_result_out, rsp_saturated);
            end
         end
      end
   end

   // watchdog: advance on cycles with no accepted beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // drain the pipeline completely before touching the registers
   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_valid || activation_queue.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic run_phase(input kind_type kind, input logic deriv, input logic [13:0] alpha,
                            input int random_items);
      logic signed [15:0] edge_values[$];
      wait_drained();
      csr_write(ADDR_FUNCTION_KIND, 32'(kind));
      csr_write(ADDR_DERIVATIVE_MODE, 32'(deriv));
      csr_write(ADDR_ELU_ALPHA, 32'(alpha));
      act_kind = kind;
      act_deriv = deriv;
      act_alpha = alpha;
      // field extremes, zero crossing, hard-sigmoid knees and the rounding tie
      edge_values = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1, 16'sd2048,
                      -16'sd2048, 16'sd6144, -16'sd6144, 16'sd6145, -16'sd6145,
                      -16'sd6147, -16'sd6141, 16'sd3};
      foreach (edge_values[i]) sample_queue.push_back(edge_values[i]);
      for (int i = 0; i < random_items; i++) begin
         if ($urandom_range(0, 1) == 0)
            sample_queue.push_back(16'($urandom_range(0, 65535)));
         else
            sample_queue.push_back(16'(int'($urandom_range(0, 32767)) - 16384));
      end
   endtask

   initial begin
      logic [13:0] alpha;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int k = int'(KIND_IDENTITY); k <= int'(KIND_TANH); k++) begin
         for (int d = 0; d < 2; d++) begin
            alpha = 14'($urandom_range(0, 16383));
            run_phase(kind_type'(k), d[0], alpha, 60);
         end
      end
      // ELU at the alpha extremes and the reset value
      run_phase(KIND_ELU, 1'b0, 14'd0, 20);
      run_phase(KIND_ELU, 1'b1, 14'd16383, 20);
      run_phase(KIND_ELU, 1'b0, 14'd16383, 20);
      run_phase(KIND_ELU, 1'b1, ELU_ALPHA_RESET, 20);
      wait_drained();
      if (mismatch_count == 0 && activation_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
